// File: design/frp_pkg.sv
`default_nettype none
package frp_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] RegMaxWidth     = 3'd0;
  localparam logic [2:0] RegHSpacing     = 3'd1;
  localparam logic [2:0] RegVSpacing     = 3'd2;
  localparam logic [2:0] RegItemLimit    = 3'd3;
  localparam logic [2:0] RegTailWidth    = 3'd4;
  localparam logic [2:0] RegReservedTail = 3'd5;

  // record kinds on the result stream
  localparam logic [1:0] KindItem    = 2'd0;
  localparam logic [1:0] KindRowBox  = 2'd1;
  localparam logic [1:0] KindSummary = 2'd2;

  localparam int unsigned DimW = 14;  // item width / height
  localparam int unsigned PosW = 20;  // positions
  localparam int unsigned SumW = 21;  // grown sums and signed sizes

  typedef struct packed {
    logic [DimW-1:0] h;
    logic [DimW-1:0] w;
  } wh_t;

  typedef struct packed {
    logic [PosW-1:0] y;
    logic [PosW-1:0] x;
  } xy_t;

endpackage
`default_nettype wire

// File: design/frp_ram.sv
`default_nettype none
module frp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: design/flow_row_packer.sv
// Flow row packer: lays a set of item sizes out in wrapped rows.
// Input stream: one item per transfer, width and height in tdata; tlast
// marks the final item of a set and starts packing. Items are taken one
// per cycle while loading; beyond ITEMS stored items they are dropped and
// the run reports overflow.
// After the final item the block packs the set out of its two item stores
// (size store and position store, one read and one write port each, with a
// registered read). Each store step is a read state and an execute state.
// Packing runs a tallest-item scan over the kept items on truncation, a
// wrap pass over the items (with a repeat read for each item that opens a
// row), row centring, emitting, and a bounding box over the last-row
// items, with more work when items are peeled off the last row.
// The input is not ready during packing and emitting.
// Results: one record per placed item, then the last row box, then the
// summary with tlast set; tuser gives the record kind. A result register
// sits on the output; a stalled receiver holds the block in its emit step.
// Reset clears the load state, configuration and output valid; no
// clearing pass is needed as only entries of the current run are read.
`default_nettype none
module flow_row_packer
  import frp_pkg::*;
#(
  parameter int unsigned ITEMS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_addr_i,
  input  wire  [15:0] cfg_data_i,
  // input items
  input  wire         s_tvalid_i,
  output logic        s_tready_o,
  input  wire  [31:0] s_tdata_i,   // item_width[13:0], item_height[27:14], zero pad
  input  wire         s_tlast_i,   // final_item
  // results
  output logic        m_tvalid_o,
  input  wire         m_tready_i,
  output logic [95:0] m_tdata_o,   // pos_x, pos_y, size_w, size_h, was_truncated,
                                   // tail_fits, placed_count, overflowed, zero pad
  output logic [1:0]  m_tuser_o,   // record_kind
  output logic        m_tlast_o    // end_of_run
);

  localparam int unsigned IW = $clog2(ITEMS);
  localparam int unsigned CW = $clog2(ITEMS + 1);

  typedef enum logic [19:0] {
    S_LOAD   = 20'h00001,
    S_TSC_RD = 20'h00002,
    S_TSC_EX = 20'h00004,
    S_TWR    = 20'h00008,
    S_PACK   = 20'h00010,
    S_WR_RD  = 20'h00020,
    S_WR_EX  = 20'h00040,
    S_CEN_RD = 20'h00080,
    S_CEN_EX = 20'h00100,
    S_FIX_RD = 20'h00200,
    S_FIX_EX = 20'h00400,
    S_NH_RD  = 20'h00800,
    S_NH_EX  = 20'h01000,
    S_MOVE   = 20'h02000,
    S_OUT_RD = 20'h04000,
    S_OUT_EX = 20'h08000,
    S_BOX_RD = 20'h10000,
    S_BOX_EX = 20'h20000,
    S_BOX_EM = 20'h40000,
    S_SUM_EM = 20'h80000
  } state_e;

  // configuration registers
  logic [15:0] max_width_q;
  logic [9:0]  h_spacing_q, v_spacing_q;
  logic [5:0]  item_limit_q;
  logic [13:0] tail_width_q, reserved_tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_width_q     <= '0;
      h_spacing_q     <= '0;
      v_spacing_q     <= '0;
      item_limit_q    <= '0;
      tail_width_q    <= '0;
      reserved_tail_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegMaxWidth:     max_width_q     <= cfg_data_i;
        RegHSpacing:     h_spacing_q     <= cfg_data_i[9:0];
        RegVSpacing:     v_spacing_q     <= cfg_data_i[9:0];
        RegItemLimit:    item_limit_q    <= cfg_data_i[5:0];
        RegTailWidth:    tail_width_q    <= cfg_data_i[13:0];
        RegReservedTail: reserved_tail_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e           state_q, state_d, ret_q, ret_d;
  logic [IW-1:0]    idx_q, idx_d, rs_q, rs_d;
  logic [CW-1:0]    cnt_q, cnt_d, n_q, n_d, cen_end_q, cen_end_d;
  logic [DimW-1:0]  tall_q, tall_d, th_q, th_d, rh_q, rh_d;
  logic [DimW-1:0]  cen_ht_q, cen_ht_d, last_h_q, last_h_d;
  logic [PosW-1:0]  y_q, y_d, cen_top_q, cen_top_d;
  logic [SumW-1:0]  x_q, x_d, maxr_q, maxr_d;
  logic [SumW-1:0]  bx0_q, bx0_d, by0_q, by0_d, bx1_q, bx1_d, by1_q, by1_d;
  logic             ovf_q, ovf_d, trunc_q, trunc_d, fits_q, fits_d, any_q, any_d;

  // output register
  logic             ov_q;
  logic [1:0]       okind_q;
  logic [PosW-1:0]  ox_q, oy_q;
  logic [SumW-1:0]  ow_q, oh_q;
  logic             oeor_q;
  logic [8:0]       oflag_q;  // trunc, fits, placed count, overflow

  // store ports
  logic             wh_we, xy_we;
  logic [IW-1:0]    wh_waddr, xy_waddr;
  wh_t              wh_wdata, wh_rd;
  xy_t              xy_wdata, xy_rd;

  frp_ram #(.WIDTH(2 * DimW), .DEPTH(ITEMS)) u_wh_ram (
    .clk_i  (clk_i),
    .we_i   (wh_we),
    .waddr_i(wh_waddr),
    .wdata_i(wh_wdata),
    .raddr_i(idx_q),
    .rdata_o(wh_rd)
  );

  frp_ram #(.WIDTH(2 * PosW), .DEPTH(ITEMS)) u_xy_ram (
    .clk_i  (clk_i),
    .we_i   (xy_we),
    .waddr_i(xy_waddr),
    .wdata_i(xy_wdata),
    .raddr_i(idx_q),
    .rdata_o(xy_rd)
  );

  // result emission
  logic            ofree, emit, e_eor;
  logic [1:0]      e_kind;
  logic [PosW-1:0] e_x, e_y;
  logic [SumW-1:0] e_w, e_h;

  assign ofree = !ov_q || m_tready_i;

  // combinational helpers
  logic [CW-1:0]   n_after, idx_nx;
  logic [IW-1:0]   last_idx;
  logic            s_acc, store_ok, first, wrap, fix_on;
  logic [SumW-1:0] ix, xr, yb, ex, ey;
  logic [SumW:0]   need;
  logic [PosW-1:0] cen_y;
  logic [DimW-1:0] half;

  assign s_tready_o = (state_q == S_LOAD);
  assign s_acc      = s_tvalid_i && s_tready_o;
  assign store_ok   = cnt_q < CW'(ITEMS);
  assign n_after    = store_ok ? cnt_q + 1'b1 : cnt_q;
  assign idx_nx     = CW'(idx_q) + 1'b1;
  assign last_idx   = IW'(n_q - 1'b1);
  assign fix_on     = (reserved_tail_q != '0) && (max_width_q != '0);

  // wrap decision for the item being read
  assign first = (idx_q == rs_q);
  assign ix    = first ? '0 : x_q + SumW'(h_spacing_q);
  assign wrap  = !first && (max_width_q != '0) &&
                 (ix + SumW'(wh_rd.w) > SumW'(max_width_q));

  // centring and box terms
  assign half  = (cen_ht_q - wh_rd.h) >> 1;
  assign cen_y = cen_top_q + PosW'(half);
  assign xr    = SumW'(xy_rd.x) + SumW'(wh_rd.w);
  assign yb    = SumW'(xy_rd.y);
  assign ex    = xr;
  assign ey    = yb + SumW'(wh_rd.h);
  assign need  = (SumW + 1)'(xr) + (SumW + 1)'(h_spacing_q) + (SumW + 1)'(reserved_tail_q);

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    idx_d     = idx_q;
    rs_d      = rs_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    cen_end_d = cen_end_q;
    tall_d    = tall_q;
    th_d      = th_q;
    rh_d      = rh_q;
    cen_ht_d  = cen_ht_q;
    last_h_d  = last_h_q;
    y_d       = y_q;
    cen_top_d = cen_top_q;
    x_d       = x_q;
    maxr_d    = maxr_q;
    bx0_d     = bx0_q;
    by0_d     = by0_q;
    bx1_d     = bx1_q;
    by1_d     = by1_q;
    ovf_d     = ovf_q;
    trunc_d   = trunc_q;
    fits_d    = fits_q;
    any_d     = any_q;

    wh_we    = 1'b0;
    wh_waddr = cnt_q[IW-1:0];
    wh_wdata = '{h: s_tdata_i[27:14], w: s_tdata_i[13:0]};
    xy_we    = 1'b0;
    xy_waddr = idx_q;
    xy_wdata = '{y: y_q, x: PosW'(ix)};

    emit   = 1'b0;
    e_kind = KindItem;
    e_x    = '0;
    e_y    = '0;
    e_w    = '0;
    e_h    = '0;
    e_eor  = 1'b0;

    case (state_q)
      // take items into the size store
      S_LOAD: begin
        if (s_acc) begin
          if (store_ok) begin
            wh_we  = 1'b1;
            cnt_d  = n_after;
            if (s_tdata_i[27:14] > tall_q) begin
              tall_d = s_tdata_i[27:14];
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (s_tlast_i) begin
            if (item_limit_q != '0 && 7'(n_after) > 7'(item_limit_q)) begin
              trunc_d = 1'b1;
              n_d     = CW'(item_limit_q);
              if (item_limit_q == 6'd1) begin
                th_d    = (store_ok && s_tdata_i[27:14] > tall_q) ?
                          s_tdata_i[27:14] : tall_q;
                state_d = S_TWR;
              end else begin
                th_d    = '0;
                idx_d   = '0;
                state_d = S_TSC_RD;
              end
            end else begin
              trunc_d = 1'b0;
              n_d     = n_after;
              state_d = S_PACK;
            end
          end
        end
      end
      // tallest of the kept items
      S_TSC_RD: state_d = S_TSC_EX;
      S_TSC_EX: begin
        if (wh_rd.h > th_q) begin
          th_d = wh_rd.h;
        end
        if (idx_nx == n_q - 1'b1) begin
          state_d = S_TWR;
        end else begin
          idx_d   = IW'(idx_nx);
          state_d = S_TSC_RD;
        end
      end
      // tail item replaces the first dropped entry
      S_TWR: begin
        wh_we    = 1'b1;
        wh_waddr = last_idx;
        wh_wdata = '{h: th_q, w: tail_width_q};
        state_d  = S_PACK;
      end
      S_PACK: begin
        x_d    = '0;
        y_d    = '0;
        rh_d   = '0;
        rs_d   = '0;
        idx_d  = '0;
        maxr_d = '0;
        any_d  = 1'b0;
        fits_d = 1'b1;
        if (n_q == '0) begin
          if (fix_on) begin
            fits_d = (16'(reserved_tail_q) <= max_width_q);
          end
          state_d = S_BOX_EM;
        end else begin
          state_d = S_WR_RD;
        end
      end
      // greedy wrap pass
      S_WR_RD: state_d = S_WR_EX;
      S_WR_EX: begin
        if (wrap) begin
          cen_end_d = CW'(idx_q);
          cen_top_d = y_q;
          cen_ht_d  = rh_q;
          y_d       = PosW'(SumW'(y_q) + SumW'(rh_q) + SumW'(v_spacing_q));
          rs_d      = idx_q;
          rh_d      = '0;
          idx_d     = rs_q;
          ret_d     = S_WR_RD;
          state_d   = S_CEN_RD;
        end else begin
          xy_we = 1'b1;
          x_d   = ix + SumW'(wh_rd.w);
          th_d  = (wh_rd.h > rh_q) ? wh_rd.h : rh_q;
          rh_d  = th_d;
          if (idx_nx == n_q) begin
            cen_end_d = n_q;
            cen_top_d = y_q;
            cen_ht_d  = th_d;
            idx_d     = rs_q;
            ret_d     = fix_on ? S_FIX_RD : S_OUT_RD;
            state_d   = S_CEN_RD;
          end else begin
            idx_d   = IW'(idx_nx);
            state_d = S_WR_RD;
          end
        end
      end
      // vertical centring of one row
      S_CEN_RD: state_d = S_CEN_EX;
      S_CEN_EX: begin
        xy_we    = 1'b1;
        xy_wdata = '{y: cen_y, x: xy_rd.x};
        if (idx_nx == cen_end_q) begin
          case (ret_q)
            S_WR_RD: idx_d = IW'(cen_end_q);
            S_OUT_RD: idx_d = '0;
            default: idx_d = last_idx;
          endcase
          state_d = ret_q;
        end else begin
          idx_d = IW'(idx_nx);
        end
        if (idx_nx != cen_end_q) begin
          state_d = S_CEN_RD;
        end
      end
      // reserved tail check on the last row
      S_FIX_RD: state_d = S_FIX_EX;
      S_FIX_EX: begin
        last_h_d = wh_rd.h;
        if (need <= (SumW + 1)'(max_width_q)) begin
          fits_d  = 1'b1;
          idx_d   = '0;
          state_d = S_OUT_RD;
        end else if (rs_q == last_idx) begin
          fits_d  = 1'b0;
          idx_d   = '0;
          state_d = S_OUT_RD;
        end else begin
          th_d    = '0;
          idx_d   = rs_q;
          state_d = S_NH_RD;
        end
      end
      S_NH_RD: state_d = S_NH_EX;
      S_NH_EX: begin
        th_d = (wh_rd.h > th_q) ? wh_rd.h : th_q;
        if (idx_q + 1'b1 == last_idx) begin
          cen_end_d = CW'(last_idx);
          cen_top_d = y_q;
          cen_ht_d  = th_d;
          idx_d     = rs_q;
          ret_d     = S_MOVE;
          state_d   = S_CEN_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_NH_RD;
        end
      end
      // last item goes to a row of its own
      S_MOVE: begin
        xy_we    = 1'b1;
        xy_waddr = last_idx;
        xy_wdata = '{y: PosW'(SumW'(y_q) + SumW'(th_q) + SumW'(v_spacing_q)), x: '0};
        y_d      = xy_wdata.y;
        rs_d     = last_idx;
        rh_d     = last_h_q;
        idx_d    = last_idx;
        state_d  = S_FIX_RD;
      end
      // item rectangles
      S_OUT_RD: state_d = S_OUT_EX;
      S_OUT_EX: begin
        if (ofree) begin
          emit   = 1'b1;
          e_kind = KindItem;
          e_x    = xy_rd.x;
          e_y    = xy_rd.y;
          e_w    = SumW'(wh_rd.w);
          e_h    = SumW'(wh_rd.h);
          if (xr > maxr_q) begin
            maxr_d = xr;
          end
          if (idx_q == last_idx) begin
            idx_d   = rs_q;
            state_d = S_BOX_RD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_OUT_RD;
          end
        end
      end
      // bounding box of the last row, empty items skipped
      S_BOX_RD: state_d = S_BOX_EX;
      S_BOX_EX: begin
        if (wh_rd.w != '0 || wh_rd.h != '0) begin
          any_d = 1'b1;
          if (!any_q) begin
            bx0_d = SumW'(xy_rd.x);
            by0_d = yb;
            bx1_d = ex;
            by1_d = ey;
          end else begin
            if (SumW'(xy_rd.x) < bx0_q) bx0_d = SumW'(xy_rd.x);
            if (yb < by0_q) by0_d = yb;
            if (ex > bx1_q) bx1_d = ex;
            if (ey > by1_q) by1_d = ey;
          end
        end
        if (idx_q == last_idx) begin
          state_d = S_BOX_EM;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_BOX_RD;
        end
      end
      S_BOX_EM: begin
        if (ofree) begin
          emit   = 1'b1;
          e_kind = KindRowBox;
          if (any_q) begin
            e_x = PosW'(bx0_q);
            e_y = PosW'(by0_q);
            e_w = bx1_q - bx0_q;
            e_h = by1_q - by0_q;
          end
          state_d = S_SUM_EM;
        end
      end
      // summary closes the run and clears the load state
      S_SUM_EM: begin
        if (ofree) begin
          emit   = 1'b1;
          e_kind = KindSummary;
          e_eor  = 1'b1;
          if (n_q == '0) begin
            e_w = '1;
            e_h = '1;
          end else begin
            e_w = maxr_q;
            e_h = SumW'(y_q) + SumW'(rh_q);
          end
          cnt_d   = '0;
          tall_d  = '0;
          ovf_d   = 1'b0;
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      ret_q   <= S_LOAD;
      cnt_q   <= '0;
      tall_q  <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      tall_q  <= tall_d;
      ovf_q   <= ovf_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (m_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    rs_q      <= rs_d;
    n_q       <= n_d;
    cen_end_q <= cen_end_d;
    th_q      <= th_d;
    rh_q      <= rh_d;
    cen_ht_q  <= cen_ht_d;
    last_h_q  <= last_h_d;
    y_q       <= y_d;
    cen_top_q <= cen_top_d;
    x_q       <= x_d;
    maxr_q    <= maxr_d;
    bx0_q     <= bx0_d;
    by0_q     <= by0_d;
    bx1_q     <= bx1_d;
    by1_q     <= by1_d;
    trunc_q   <= trunc_d;
    fits_q    <= fits_d;
    any_q     <= any_d;
    if (emit) begin
      okind_q <= e_kind;
      ox_q    <= e_x;
      oy_q    <= e_y;
      ow_q    <= e_w;
      oh_q    <= e_h;
      oeor_q  <= e_eor;
      oflag_q <= {ovf_q, 6'(n_q), fits_q, trunc_q};
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_tuser_o  = okind_q;
  assign m_tlast_o  = oeor_q;
  assign m_tdata_o  = {5'd0, oflag_q, oh_q, ow_q, oy_q, ox_q};

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import frp_pkg::*;

  localparam int unsigned Items = 32;
  localparam longint unsigned Sat20 = 64'd1048575;

  // one record on the result stream, unpacked
  typedef struct {
    logic [1:0]  kind;
    logic [19:0] x;
    logic [19:0] y;
    logic [20:0] w;
    logic [20:0] h;
    logic        trunc;
    logic        fits;
    logic [5:0]  placed;
    logic        ovf;
    logic        eor;
  } layout_rec_t;

  // layout predictor and store of expected records
  class layout_board;
    int unsigned wst[Items], hst[Items], xst[Items], yst[Items];
    int unsigned loaded, tallest;
    bit          ovf_seen;
    int unsigned max_width, h_sp, v_sp, item_limit, tail_w, resv_tail;
    bit          run_trunc, run_fits, run_ovf;
    int unsigned run_placed;
    layout_rec_t pending_q[$];
    int          errors;
    int          checked;

    function new();
      loaded = 0; tallest = 0; ovf_seen = 0;
      max_width = 0; h_sp = 0; v_sp = 0; item_limit = 0; tail_w = 0; resv_tail = 0;
      errors = 0; checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, int unsigned val);
      case (idx)
        RegMaxWidth:     max_width  = val & 16'hFFFF;
        RegHSpacing:     h_sp       = val & 10'h3FF;
        RegVSpacing:     v_sp       = val & 10'h3FF;
        RegItemLimit:    item_limit = val & 6'h3F;
        RegTailWidth:    tail_w     = val & 14'h3FFF;
        RegReservedTail: resv_tail  = val & 14'h3FFF;
        default: ;
      endcase
    endfunction

    function logic [19:0] sat20(longint unsigned v);
      return (v > Sat20) ? 20'hFFFFF : v[19:0];
    endfunction

    function void centre(int unsigned a, int unsigned b, int unsigned top, int unsigned ht);
      int unsigned i;
      for (i = a; i < b && i < Items; i++) yst[i] = top + (ht - hst[i]) / 2;
    endfunction

    function void push(logic [1:0] kind, longint unsigned x, longint unsigned y,
                       longint w, longint h, bit eor);
      layout_rec_t r;
      r.kind = kind;
      r.x = sat20(x);
      r.y = sat20(y);
      r.w = (w < 0) ? 21'h1FFFFF : {1'b0, sat20(w)};
      r.h = (h < 0) ? 21'h1FFFFF : {1'b0, sat20(h)};
      r.trunc = run_trunc;
      r.fits = run_fits;
      r.placed = run_placed[5:0];
      r.ovf = run_ovf;
      r.eor = eor;
      pending_q = {pending_q, r};
    endfunction

    // note one accepted item; on the final item lay out the set
    function void note_item(int unsigned w, int unsigned h, bit fin);
      int unsigned n, keep, th, x, y, rh, rs, ix, last, cnt, nh, ny, need, i;
      int unsigned row_start, row_top, row_height;
      bit first, done, anyb;
      longint unsigned bx0, by0, bx1, by1, maxr, r, ax, ay, ex, ey;
      if (loaded < Items) begin
        wst[loaded] = w;
        hst[loaded] = h;
        if (h > tallest) tallest = h;
        loaded++;
      end else begin
        ovf_seen = 1;
      end
      if (!fin) return;

      // truncation with tail item
      n = loaded;
      run_trunc = 0;
      if (item_limit > 0 && n > item_limit) begin
        keep = item_limit - 1;
        th = 0;
        for (i = 0; i < keep; i++) if (hst[i] > th) th = hst[i];
        if (keep == 0) th = tallest;
        wst[keep] = tail_w;
        hst[keep] = th;
        n = keep + 1;
        run_trunc = 1;
      end

      // greedy wrap
      x = 0; y = 0; rh = 0; rs = 0;
      for (i = 0; i < n; i++) begin
        first = (i == rs);
        ix = first ? 0 : x + h_sp;
        if (!first && max_width > 0 && ix + wst[i] > max_width) begin
          centre(rs, i, y, rh);
          y += rh + v_sp;
          rs = i; ix = 0; rh = 0;
        end
        xst[i] = ix;
        yst[i] = y;
        x = ix + wst[i];
        if (hst[i] > rh) rh = hst[i];
      end
      if (n > rs) centre(rs, n, y, rh);
      row_start = rs; row_top = y; row_height = rh;

      // peel items off the last row until the reserved tail fits
      run_fits = 1;
      if (resv_tail > 0 && max_width > 0) begin
        if (n == 0) begin
          run_fits = resv_tail <= max_width;
        end else begin
          done = 0;
          while (!done) begin
            last = n - 1;
            cnt = n - row_start;
            nh = 0;
            need = xst[last] + wst[last] + h_sp + resv_tail;
            if (need <= max_width) begin
              run_fits = 1; done = 1;
            end else if (cnt <= 1) begin
              run_fits = 0; done = 1;
            end else begin
              for (i = row_start; i < last; i++) if (hst[i] > nh) nh = hst[i];
              centre(row_start, last, row_top, nh);
              ny = row_top + nh + v_sp;
              xst[last] = 0;
              yst[last] = ny;
              row_start = last; row_top = ny; row_height = hst[last];
            end
          end
        end
      end

      run_placed = n;
      run_ovf = ovf_seen;

      maxr = 0;
      for (i = 0; i < n; i++) begin
        r = longint'(xst[i]) + wst[i];
        if (r > maxr) maxr = r;
        push(KindItem, xst[i], yst[i], wst[i], hst[i], 0);
      end

      // last row box, empty items ignored
      anyb = 0; bx0 = 0; by0 = 0; bx1 = 0; by1 = 0;
      for (i = row_start; i < n; i++) begin
        ax = xst[i]; ay = yst[i];
        ex = ax + wst[i]; ey = ay + hst[i];
        if (!(wst[i] == 0 && hst[i] == 0)) begin
          if (!anyb) begin
            bx0 = ax; by0 = ay; bx1 = ex; by1 = ey; anyb = 1;
          end else begin
            if (ax < bx0) bx0 = ax;
            if (ay < by0) by0 = ay;
            if (ex > bx1) bx1 = ex;
            if (ey > by1) by1 = ey;
          end
        end
      end
      push(KindRowBox, bx0, by0, bx1 - bx0, by1 - by0, 0);

      if (n == 0) push(KindSummary, 0, 0, -1, -1, 1);
      else push(KindSummary, 0, 0, maxr, longint'(row_top) + row_height, 1);

      loaded = 0; tallest = 0; ovf_seen = 0;
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %0t: %s got %0h want %0h", $time, what, got, want);
      errors++;
    endtask

    // compare one accepted record with the oldest expectation
    task check(logic [1:0] kind, logic [95:0] d, logic eor);
      layout_rec_t e;
      if (pending_q.size() == 0) begin
        report("record with nothing expected, kind", kind, 0);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (kind !== e.kind)       report("record_kind", kind, e.kind);
      if (d[19:0] !== e.x)       report("pos_x", d[19:0], e.x);
      if (d[39:20] !== e.y)      report("pos_y", d[39:20], e.y);
      if (d[60:40] !== e.w)      report("size_w", d[60:40], e.w);
      if (d[81:61] !== e.h)      report("size_h", d[81:61], e.h);
      if (d[82] !== e.trunc)     report("was_truncated", d[82], e.trunc);
      if (d[83] !== e.fits)      report("tail_fits", d[83], e.fits);
      if (d[89:84] !== e.placed) report("placed_count", d[89:84], e.placed);
      if (d[90] !== e.ovf)       report("overflowed", d[90], e.ovf);
      if (eor !== e.eor)         report("end_of_run", eor, e.eor);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [31:0] s_tdata_i = '0;
  logic        s_tlast_i = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [95:0] m_tdata_o;
  logic [1:0]  m_tuser_o;
  logic        m_tlast_o;

  layout_board board = new();
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int items_sent = 0;
  int sets_sent = 0;

  flow_row_packer #(.ITEMS(Items)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .s_tvalid_i, .s_tready_o, .s_tdata_i, .s_tlast_i,
    .m_tvalid_o, .m_tready_i, .m_tdata_o, .m_tuser_o, .m_tlast_o
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_tready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid_i && s_tready_o)
      board.note_item(s_tdata_i[13:0], s_tdata_i[27:14], s_tlast_i);
    if (rst_ni && m_tvalid_o && m_tready_i)
      board.check(m_tuser_o, m_tdata_o, m_tlast_o);
  end

  task write_reg(logic [2:0] idx, int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val[15:0];
    board.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task set_layout(int unsigned mw, int unsigned hs, int unsigned vs,
                  int unsigned il, int unsigned tw, int unsigned rt);
    write_reg(RegMaxWidth, mw);
    write_reg(RegHSpacing, hs);
    write_reg(RegVSpacing, vs);
    write_reg(RegItemLimit, il);
    write_reg(RegTailWidth, tw);
    write_reg(RegReservedTail, rt);
  endtask

  // offer one item and hold it until taken
  task send_item(int unsigned w, int unsigned h, bit fin);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= {4'b0, h[13:0], w[13:0]};
    s_tlast_i <= fin;
    do @(posedge clk_i); while (!s_tready_o);
    @(negedge clk_i);
    items_sent++;
    if (fin) sets_sent++;
  endtask

  task go_quiet();
    s_tvalid_i <= 1'b0;
    s_tlast_i <= 1'b0;
  endtask

  // wait for every expected record, then let the block settle
  task drain();
    go_quiet();
    while (board.pending_q.size() > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task random_layout();
    int unsigned mw, rt;
    case ($urandom_range(3))
      0: mw = 0;
      1: mw = $urandom_range(1, 300);
      2: mw = $urandom_range(300, 5000);
      default: mw = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(3))
      0: rt = 0;
      1: rt = 16383;
      default: rt = $urandom_range(0, 200);
    endcase
    set_layout(mw, $urandom_range(0, 1023) >> $urandom_range(0, 10),
               $urandom_range(0, 1023) >> $urandom_range(0, 10),
               ($urandom_range(2) == 0) ? $urandom_range(0, 32) : 0,
               $urandom_range(0, 16383) >> $urandom_range(0, 14), rt);
  endtask

  task random_set(int unsigned len);
    int unsigned cap, i, w, h;
    cap = ($urandom_range(2) == 0) ? 16383 : $urandom_range(1, 400);
    for (i = 0; i < len; i++) begin
      w = ($urandom_range(9) == 0) ? 16383 * $urandom_range(1) : $urandom_range(0, cap);
      h = ($urandom_range(9) == 0) ? 16383 * $urandom_range(1) : $urandom_range(0, cap);
      send_item(w, h, i == len - 1);
    end
  endtask

  function int unsigned set_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 80) return $urandom_range(1, 6);
    if (p < 96) return $urandom_range(7, 16);
    return $urandom_range(33, 35);
  endfunction

  initial begin
    int ph;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset layout, largest item alone
    send_item(16383, 16383, 1);
    drain();
    // wrap with spacing, an empty item inside a row
    set_layout(100, 5, 3, 0, 0, 0);
    send_item(40, 10, 0); send_item(40, 20, 0); send_item(40, 7, 0);
    send_item(0, 0, 0); send_item(30, 31, 1);
    drain();
    // truncation with tail, reservation fits beside the tail item
    set_layout(100, 5, 3, 3, 25, 30);
    send_item(20, 8, 0); send_item(50, 3, 0); send_item(10, 9, 0);
    send_item(5, 40, 0); send_item(7, 7, 1);
    drain();
    // limit of one: the tail alone takes the tallest height
    set_layout(50, 0, 0, 1, 12, 0);
    send_item(3, 5, 0); send_item(4, 99, 0); send_item(6, 2, 1);
    drain();
    // reservation cannot fit beside a single item
    set_layout(10, 0, 0, 0, 0, 20);
    send_item(5, 5, 1);
    drain();
    // every register but the item limit at its top value
    set_layout(65535, 1023, 1023, 32, 16383, 16383);
    send_item(16383, 0, 0); send_item(0, 16383, 0); send_item(16383, 16383, 1);
    drain();

    for (ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 29 : (ph == 1) ? 58 : 0;
      recv_idle = (ph == 0) ? 58 : (ph == 1) ? 29 : 0;
      random_layout();
      if (ph == 0) begin
        // long receiver hold-off while two sets back up behind it
        hold_left = 400;
        random_set(12);
        random_set(5);
        drain();
      end
      if (ph == 2) begin
        random_layout();
        random_set(35);
        drain();
      end
      while (items_sent < 50 * (ph + 1)) begin
        random_set(set_len());
        if ($urandom_range(2) == 0) begin
          drain();
          random_layout();
        end
      end
      drain();
    end

    repeat (50) @(negedge clk_i);
    $display("covered %0d sets of %0d items, %0d records checked", sets_sent, items_sent,
             board.checked);
    $display("three stall mixes, truncation, row peeling and store overflow exercised");
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("PASS flow_row_packer");
    end else begin
      $display("FAIL flow_row_packer");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("FAIL flow_row_packer");
    $finish;
  end

endmodule
